FILE: sv/fpa_pkg.sv
// Shared types and constants for the FIR filter with peak-driven gain control.
// No dependencies; the interfaces and the top level import this package.
`default_nettype none

package fpa_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int PROD_W      = 32;
    localparam int OUT_W       = 16;
    localparam int GAIN_W      = 12;
    localparam int THR_W       = 14;
    localparam int WIN_W       = 9;
    localparam int PEAK_W      = 16;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 3;
    localparam int ROUND_SHIFT = 30;

    localparam int OUT_MAX = 32767;
    localparam int OUT_MIN = -32768;
    localparam int AVG_MAX = 8191;

    localparam logic [PEAK_W-1:0] PEAK_MAX   = 16'h7FFF;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 12'd1024;
    localparam logic [GAIN_W-1:0] GAIN_MAX   = 12'hFFF;
    localparam logic [WIN_W-1:0]  WIN_RESET  = 9'd256;
    localparam logic [THR_W-1:0]  THR_HI_RESET = 14'd128;
    localparam logic [THR_W-1:0]  THR_LO_RESET = 14'd64;
    localparam logic [GAIN_W-1:0] STEP_RESET = 12'd16;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_COEFFS_LOW     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COEFFS_HIGH    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_SAMPLES = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_HIGH_THRESHOLD = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_LOW_THRESHOLD  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_STEP      = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_GAIN,
        S_ROUND,
        S_WIN,
        S_AVG,
        S_ADJ,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: sv/fpa_in_if.sv
// Sample input channel: valid/ready handshake carrying one Q1.15 sample.
// Depends on fpa_pkg for the sample width.
`default_nettype none

interface fpa_in_if;
    import fpa_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

FILE: sv/fpa_out_if.sv
// Result channel: valid/ready handshake carrying the filtered sample and its gain.
// Depends on fpa_pkg for the field widths.
`default_nettype none

interface fpa_out_if;
    import fpa_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] filtered_out;
    logic [GAIN_W-1:0]       current_gain;

    modport source (output valid, output filtered_out, output current_gain, input ready);
    modport sink   (input valid, input filtered_out, input current_gain, output ready);
endinterface

`default_nettype wire

FILE: sv/fpa_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module fpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: sv/fir_filter_with_peak_agc.sv
// FIR filter with peak-driven automatic gain control, top level.
// Depends on fpa_pkg, fpa_in_if, fpa_out_if and fpa_ram.
// Usage:
//   i_in carries one signed Q1.15 sample per transfer. o_out carries one
//   result per sample: the filtered sample times the gain (signed Q6.10,
//   rounded half up, saturated) and the gain that was applied. The
//   configuration port writes one register per cycle while i_cfg_we is high;
//   the block must be idle when it is written.
// Datapath:
//   The tap delay line and the peak history sit in single-port-write RAMs.
//   One shared 16x16 multiplier walks the taps, one read per cycle; a new
//   sample is accepted only once the previous one has finished its steps.
//   A sample that closes a peak window also walks the history RAM one entry
//   per cycle.
// Reset: the synchronous reset restores the register defaults, a gain of 1.0
//   and empty delay line and history (valid bits make unwritten entries read 0).
// Back-pressure: the result sits in an output register; the next sample is
//   taken while it waits, and that sample's processing holds at its last step
//   until the output register is free.
`default_nettype none

module fir_filter_with_peak_agc #(
    parameter int TAPS       = 8,
    parameter int PEAK_DEPTH = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    fpa_in_if.sink                           i_in,
    fpa_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [fpa_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [fpa_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import fpa_pkg::*;

    localparam int DAW     = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int HAW     = (PEAK_DEPTH > 1) ? $clog2(PEAK_DEPTH) : 1;
    localparam int CNT_TOP = ((TAPS > PEAK_DEPTH) ? TAPS : PEAK_DEPTH) + 1;
    localparam int CW      = $clog2(CNT_TOP + 1);
    localparam int ACC_W   = PROD_W + $clog2(TAPS);
    localparam int GP_W    = ACC_W + GAIN_W + 1;
    // History sum plus rounding term, and its division by 4 * PEAK_DEPTH
    // done as a multiplication by a reciprocal that is exact over TW bits.
    localparam int TW      = PEAK_W + $clog2(PEAK_DEPTH) + 1;
    localparam int DIV     = 4 * PEAK_DEPTH;
    localparam int DIV_L   = $clog2(DIV);
    localparam int SH      = TW + DIV_L;
    localparam longint unsigned RECIP = (64'd1 << SH) / DIV + 1;
    localparam int AP_W    = 2 * TW + 1;

    localparam logic signed [GP_W-1:0] HALF = GP_W'(1) << (ROUND_SHIFT - 1);
    localparam logic signed [GP_W-1:0] Y_HI = GP_W'(OUT_MAX);
    localparam logic signed [GP_W-1:0] Y_LO = GP_W'(OUT_MIN);

    // Configuration registers.
    logic [CFG_DATA_W-1:0] r_coef_lo, r_coef_hi;
    logic [WIN_W-1:0]      r_window;
    logic [THR_W-1:0]      r_thr_hi, r_thr_lo;
    logic [GAIN_W-1:0]     r_step;

    // Control state.
    t_state                r_state, n_state;
    logic [CW-1:0]         r_cnt;
    logic [DAW-1:0]        r_wp, r_daddr, r_rd_tap;
    logic [TAPS-1:0]       r_dvalid;
    logic                  r_rd_v, r_dvld_q, r_prod_v;
    logic [HAW-1:0]        r_hp, r_haddr;
    logic [PEAK_DEPTH-1:0] r_hvalid;
    logic                  r_hrd_v, r_hvld_q;
    logic [WIN_W-1:0]      r_count;
    logic [PEAK_W-1:0]     r_wpeak;
    logic [GAIN_W-1:0]     r_gain;
    logic                  r_out_valid;

    // Datapath registers.
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [GP_W-1:0]   r_gprod;
    logic signed [OUT_W-1:0]  r_y;
    logic [GAIN_W-1:0]        r_app;
    logic [PEAK_W-1:0]        r_mag;
    logic [TW-1:0]            r_total;
    logic [AP_W-1:0]          r_avgprod;
    logic signed [OUT_W-1:0]  r_out_y;
    logic [GAIN_W-1:0]        r_out_gain;

    // Combinational signals.
    logic                     w_accept, w_issue_d, w_issue_h, w_hwe, w_load, w_out_free;
    logic [SAMPLE_W-1:0]      w_drdata;
    logic [PEAK_W-1:0]        w_hrdata;
    logic [2*CFG_DATA_W-1:0]  w_coeffs;
    logic signed [COEF_W-1:0] w_coef;
    logic signed [SAMPLE_W-1:0] w_dtap;
    logic signed [GP_W-1:0]   w_rnd, w_shift;
    logic signed [OUT_W-1:0]  w_y;
    logic [PEAK_W-1:0]        w_mag;
    logic                     w_close;
    logic [TW-1:0]            w_hadd, w_tbase, w_tot_rnd;
    logic [AP_W-1:0]          w_q;
    logic [THR_W-1:0]         w_avg;
    logic [GAIN_W-1:0]        w_gain_dn, w_gain_up;
    logic [GAIN_W:0]          w_gain_sum;
    logic [DAW-1:0]           w_daddr_dec, w_wp_inc;
    logic [HAW-1:0]           w_hp_dec, w_haddr_inc;

    fpa_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(TAPS)
    ) u_delay_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (r_wp),
        .i_wdata (i_in.sample_in),
        .i_raddr (r_daddr),
        .o_rdata (w_drdata)
    );

    fpa_ram #(
        .WIDTH(PEAK_W),
        .DEPTH(PEAK_DEPTH)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_hwe),
        .i_waddr (r_hp),
        .i_wdata (r_wpeak),
        .i_raddr (r_haddr),
        .o_rdata (w_hrdata)
    );

    // Circular pointer arithmetic.
    assign w_daddr_dec = (r_daddr == '0) ? DAW'(TAPS - 1) : r_daddr - 1'b1;
    assign w_wp_inc    = (r_wp == DAW'(TAPS - 1)) ? '0 : r_wp + 1'b1;
    assign w_hp_dec    = (r_hp == '0) ? HAW'(PEAK_DEPTH - 1) : r_hp - 1'b1;
    assign w_haddr_inc = (r_haddr == HAW'(PEAK_DEPTH - 1)) ? '0 : r_haddr + 1'b1;

    // Multiply-accumulate operands.
    assign w_coeffs = {r_coef_hi, r_coef_lo};
    assign w_coef   = w_coeffs[r_rd_tap * COEF_W +: COEF_W];
    assign w_dtap   = r_dvld_q ? w_drdata : '0;

    // Rounding, saturation and magnitude of the output.
    assign w_rnd   = r_gprod + HALF;
    assign w_shift = w_rnd >>> ROUND_SHIFT;

    always_comb begin
        if (w_shift > Y_HI) begin
            w_y = OUT_W'(OUT_MAX);
        end else if (w_shift < Y_LO) begin
            w_y = OUT_W'(OUT_MIN);
        end else begin
            w_y = OUT_W'(w_shift);
        end
        if (w_y == OUT_W'(OUT_MIN)) begin
            w_mag = PEAK_MAX;
        end else if (w_y < 0) begin
            w_mag = PEAK_W'(-w_y);
        end else begin
            w_mag = PEAK_W'(w_y);
        end
    end

    assign w_close = (r_count >= r_window);

    // History sum and average.
    assign w_hadd    = (r_hrd_v && r_hvld_q) ? TW'(w_hrdata) : '0;
    assign w_tbase   = (r_cnt == '0) ? TW'(r_wpeak) : r_total;
    assign w_tot_rnd = r_total + TW'(2 * PEAK_DEPTH);
    assign w_q       = r_avgprod >> SH;
    assign w_avg     = (w_q > AP_W'(AVG_MAX)) ? THR_W'(AVG_MAX) : THR_W'(w_q);

    // Gain adjustment with saturation at both ends.
    assign w_gain_dn  = (r_gain > r_step) ? r_gain - r_step : '0;
    assign w_gain_sum = {1'b0, r_gain} + {1'b0, r_step};
    assign w_gain_up  = w_gain_sum[GAIN_W] ? GAIN_MAX : w_gain_sum[GAIN_W-1:0];

    assign w_out_free = !r_out_valid || o_out.ready;

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.filtered_out = r_out_y;
    assign o_out.current_gain = r_out_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        w_accept  = 1'b0;
        w_issue_d = 1'b0;
        w_issue_h = 1'b0;
        w_hwe     = 1'b0;
        w_load    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    w_accept = 1'b1;
                    n_state  = S_MAC;
                end
            end
            S_MAC: begin
                w_issue_d = (r_cnt < CW'(TAPS));
                if (r_cnt == CW'(TAPS + 1)) begin
                    n_state = S_GAIN;
                end
            end
            S_GAIN: begin
                n_state = S_ROUND;
            end
            S_ROUND: begin
                if (w_close) begin
                    n_state = S_WIN;
                end else if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WIN: begin
                w_hwe     = (r_cnt == '0);
                w_issue_h = (r_cnt < CW'(PEAK_DEPTH - 1));
                if (r_cnt == CW'(PEAK_DEPTH - 1)) begin
                    n_state = S_AVG;
                end
            end
            S_AVG: begin
                n_state = S_ADJ;
            end
            S_ADJ: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_lo   <= '0;
            r_coef_hi   <= '0;
            r_window    <= WIN_RESET;
            r_thr_hi    <= THR_HI_RESET;
            r_thr_lo    <= THR_LO_RESET;
            r_step      <= STEP_RESET;
            r_cnt       <= '0;
            r_wp        <= '0;
            r_daddr     <= '0;
            r_rd_tap    <= '0;
            r_dvalid    <= '0;
            r_rd_v      <= 1'b0;
            r_dvld_q    <= 1'b0;
            r_prod_v    <= 1'b0;
            r_hp        <= '0;
            r_haddr     <= '0;
            r_hvalid    <= '0;
            r_hrd_v     <= 1'b0;
            r_hvld_q    <= 1'b0;
            r_count     <= '0;
            r_wpeak     <= '0;
            r_gain      <= GAIN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_COEFFS_LOW:     r_coef_lo <= i_cfg_data;
                    CFG_COEFFS_HIGH:    r_coef_hi <= i_cfg_data;
                    CFG_WINDOW_SAMPLES: r_window  <= i_cfg_data[WIN_W-1:0];
                    CFG_HIGH_THRESHOLD: r_thr_hi  <= i_cfg_data[THR_W-1:0];
                    CFG_LOW_THRESHOLD:  r_thr_lo  <= i_cfg_data[THR_W-1:0];
                    CFG_GAIN_STEP:      r_step    <= i_cfg_data[GAIN_W-1:0];
                    default: begin
                    end
                endcase
            end

            // Tap read pipeline: address, then RAM data, then product.
            r_rd_v   <= w_issue_d;
            r_dvld_q <= r_dvalid[r_daddr];
            r_rd_tap <= r_cnt[DAW-1:0];
            r_prod_v <= r_rd_v;
            r_hrd_v  <= w_issue_h;
            r_hvld_q <= r_hvalid[r_haddr];

            if (w_accept) begin
                r_dvalid[r_wp] <= 1'b1;
                r_daddr        <= r_wp;
                r_wp           <= w_wp_inc;
                r_cnt          <= '0;
            end

            if (r_state == S_MAC) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_issue_d) begin
                    r_daddr <= w_daddr_dec;
                end
            end

            if (r_state == S_ROUND) begin
                if (w_close) begin
                    // Newest peak goes one slot behind the current head.
                    r_count <= WIN_W'(1);
                    r_hp    <= w_hp_dec;
                    r_haddr <= r_hp;
                    r_cnt   <= '0;
                end else begin
                    r_count <= r_count + 1'b1;
                    if (w_mag > r_wpeak) begin
                        r_wpeak <= w_mag;
                    end
                end
            end

            if (r_state == S_WIN) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_hwe) begin
                    r_hvalid[r_hp] <= 1'b1;
                    r_wpeak        <= r_mag;
                end
                if (w_issue_h) begin
                    r_haddr <= w_haddr_inc;
                end
            end

            if (r_state == S_ADJ) begin
                if ($signed(w_avg) > $signed(r_thr_hi)) begin
                    r_gain <= w_gain_dn;
                end else if ($signed(w_avg) < $signed(r_thr_lo)) begin
                    r_gain <= w_gain_up;
                end
            end

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= w_dtap * w_coef;
        if (w_accept) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        r_gprod <= r_acc * $signed({1'b0, r_gain});
        if (r_state == S_ROUND) begin
            r_y   <= w_y;
            r_app <= r_gain;
            r_mag <= w_mag;
        end
        if (r_state == S_WIN) begin
            r_total <= w_tbase + w_hadd;
        end
        r_avgprod <= AP_W'(w_tot_rnd) * AP_W'(RECIP);
        if (w_load) begin
            r_out_y    <= (r_state == S_ROUND) ? w_y : r_y;
            r_out_gain <= (r_state == S_ROUND) ? r_gain : r_app;
        end
    end

    // The last product of the tap walk is ready exactly when the walk ends.
    a_mac_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC && r_cnt == CW'(TAPS + 1)) |-> r_prod_v)
        else $error("tap product pipeline out of step with the tap counter");

    // No read is in flight once the block is idle again.
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_rd_v && !r_prod_v && !r_hrd_v))
        else $error("RAM read still in flight in idle state");

    // The history write never hits the entry being read in the same cycle.
    a_hist_no_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_hwe && w_issue_h) |-> (r_haddr != r_hp))
        else $error("history RAM read and write to the same entry");

    // A result appears only after a finishing step.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_out_valid))
            |-> $past(r_state == S_ROUND || r_state == S_DONE))
        else $error("result loaded outside a finishing step");

    // The gain moves only in the adjust step of a closed window.
    a_gain_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_gain)) |-> $past(r_state == S_ADJ))
        else $error("gain changed outside the window adjust step");

endmodule

`default_nettype wire
